@@ src/tyrd_pkg.sv @@
// Shared types, codes and pixel conversion helpers for the tiled run image decoder.
package tyrd_pkg;

    // Operation kinds passed from the parser to the pixel back end
    localparam logic [1:0] OP_TILE  = 2'd0;
    localparam logic [1:0] OP_TRANS = 2'd1;
    localparam logic [1:0] OP_STAT  = 2'd2;

    // Run modes
    localparam logic [1:0] MODE_YCC   = 2'd0;
    localparam logic [1:0] MODE_TRANS = 2'd1;
    localparam logic [1:0] MODE_RGB   = 2'd2;
    localparam logic [1:0] MODE_BAD   = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_TILE = 2'd0;
    localparam logic [1:0] ST_ERR  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam int OFS_W = 25;
    localparam int CNT_W = 12;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [1:0]       mode;
        logic [1:0]       status;
        logic [OFS_W-1:0] offset;
        logic [CNT_W-1:0] count;
        byte_t [11:0]     data;
    } op_t;

    // Clip a signed value to 0..255
    function automatic logic [7:0] clip8(input logic signed [11:0] v);
        logic [7:0] r;
        if (v < 0)
            r = 8'd0;
        else if (v > 12'sd255)
            r = 8'd255;
        else
            r = v[7:0];
        return r;
    endfunction

    // Fixed-point YCrCb to ABGR, arithmetic shift gives floor division by 1024
    function automatic logic [31:0] ycc_pixel(input byte_t y, input byte_t cr,
                                              input byte_t cb);
        logic signed [8:0]  dr;
        logic signed [8:0]  db;
        logic signed [19:0] pr;
        logic signed [19:0] pg1;
        logic signed [19:0] pg2;
        logic signed [19:0] pb;
        logic signed [11:0] yy;
        logic signed [11:0] rr;
        logic signed [11:0] gg;
        logic signed [11:0] bb;
        dr  = $signed({1'b0, cr}) - 9'sd128;
        db  = $signed({1'b0, cb}) - 9'sd128;
        pr  = 20'sd1357 * 20'(dr);
        pg1 = 20'sd691 * 20'(dr);
        pg2 = 20'sd333 * 20'(db);
        pb  = 20'sd1715 * 20'(db);
        yy  = $signed({4'd0, y});
        rr  = yy + 12'(pr >>> 10);
        gg  = yy - 12'(pg1 >>> 10) - 12'(pg2 >>> 10);
        bb  = yy + 12'(pb >>> 10);
        return {8'hFF, clip8(bb), clip8(gg), clip8(rr)};
    endfunction

    // RGB bytes to ABGR, alpha left clear on the transparent color
    function automatic logic [31:0] rgb_pixel(input byte_t r, input byte_t g,
                                              input byte_t b, input logic [31:0] tc);
        logic [31:0] c;
        c = {8'h00, b, g, r};
        if (c != tc)
            c[31:24] = 8'hFF;
        return c;
    endfunction

endpackage

@@ src/tyrd_front.sv @@
// Byte parser: tracks headers, run counts, tile bytes and position, issues operations.
module tyrd_front
    import tyrd_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  byte_t       stream_byte,
    input  logic        frame_start,
    input  logic [12:0] image_width,
    input  logic [12:0] image_height,
    output logic        push,
    output op_t         op
);

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_COUNT  = 2'd1;
    localparam logic [1:0] PH_DATA   = 2'd2;
    localparam logic [13:0] MAX_W14 = 14'(MAX_WIDTH);
    localparam logic [13:0] MAX_H14 = 14'(MAX_HEIGHT);
    localparam logic [14:0] COL_MAX = 15'd16383;

    logic [1:0]       phase_reg, phase_next;
    logic [1:0]       mode_reg, mode_next;
    logic [3:0]       ech_reg, ech_next;
    logic [11:0]      left_reg, left_next;
    logic [3:0]       bit_reg, bit_next;
    logic [13:0]      col_reg, col_next;
    logic [12:0]      row_reg, row_next;
    logic [OFS_W-1:0] lin_reg, lin_next;
    logic             stop_reg, stop_next;
    byte_t            tb_reg [11];

    logic [1:0]       c_phase;
    logic [3:0]       c_bit;
    logic             c_stop;
    logic [13:0]      w_eff;
    logic [13:0]      h_eff;
    logic             do_run;
    logic [11:0]      run_cnt;
    logic [14:0]      col_sum;
    logic [3:0]       need;
    logic             tb_we;

    assign w_eff = ({1'b0, image_width} < MAX_W14) ? {1'b0, image_width} : MAX_W14;
    assign h_eff = ({1'b0, image_height} < MAX_H14) ? {1'b0, image_height} : MAX_H14;

    // Next-state and operation decode for one byte
    always_comb
    begin
        c_phase    = frame_start ? PH_HEADER : phase_reg;
        mode_next  = frame_start ? MODE_YCC : mode_reg;
        ech_next   = frame_start ? 4'd0 : ech_reg;
        left_next  = frame_start ? 12'd0 : left_reg;
        c_bit      = frame_start ? 4'd0 : bit_reg;
        col_next   = frame_start ? 14'd0 : col_reg;
        row_next   = frame_start ? 13'd0 : row_reg;
        lin_next   = frame_start ? '0 : lin_reg;
        c_stop     = frame_start ? 1'b0 : stop_reg;
        phase_next = c_phase;
        bit_next   = c_bit;
        stop_next  = c_stop;
        push       = 1'b0;
        op         = '0;
        do_run     = 1'b0;
        run_cnt    = 12'd0;
        col_sum    = 15'd0;
        need       = 4'd0;
        tb_we      = 1'b0;
        if (!c_stop)
        begin
            unique case (c_phase)
                PH_HEADER:
                begin
                    if (col_next >= w_eff)
                    begin
                        col_next = col_next - w_eff;
                        row_next = row_next + 13'd2;
                        lin_next = lin_next + OFS_W'(w_eff);
                    end
                    // only a wrap can end the image
                    if (({1'b0, row_next} + 14'd1 >= h_eff) &&
                        ((frame_start ? 14'd0 : col_reg) >= w_eff))
                    begin
                        stop_next = 1'b1;
                        push      = 1'b1;
                        op.kind   = OP_STAT;
                        op.status = ST_DONE;
                    end
                    else if (stream_byte[7:6] != 2'b11)
                    begin
                        mode_next = stream_byte[7:6];
                        do_run    = 1'b1;
                        run_cnt   = {6'd0, stream_byte[5:0]};
                    end
                    else
                    begin
                        mode_next  = stream_byte[5:4];
                        ech_next   = stream_byte[3:0];
                        phase_next = PH_COUNT;
                    end
                end
                PH_COUNT:
                begin
                    do_run  = 1'b1;
                    run_cnt = {ech_next, stream_byte};
                end
                PH_DATA:
                begin
                    tb_we    = (c_bit < 4'd11);
                    need     = (mode_next == MODE_YCC) ? 4'd6 : 4'd12;
                    bit_next = c_bit + 4'd1;
                    if (bit_next >= need)
                    begin
                        push      = 1'b1;
                        op.kind   = OP_TILE;
                        op.mode   = mode_next;
                        op.status = ST_TILE;
                        op.offset = lin_next;
                        op.count  = 12'd1;
                        for (int i = 0; i < 12; i++)
                        begin
                            if (4'(i) == need - 4'd1 || i == 11)
                                op.data[i] = stream_byte;
                            else
                                op.data[i] = tb_reg[i];
                        end
                        lin_next = lin_next + OFS_W'(2);
                        bit_next = 4'd0;
                        if (left_next != 12'd0)
                            left_next = left_next - 12'd1;
                        if (left_next == 12'd0)
                            phase_next = PH_HEADER;
                    end
                end
                default:
                begin
                    phase_next = PH_HEADER;
                end
            endcase

            // Start of a run once its count is known
            if (do_run)
            begin
                phase_next = PH_HEADER;
                if (run_cnt != 12'd0)
                begin
                    col_sum  = {1'b0, col_next} + {2'b0, run_cnt, 1'b0};
                    col_next = (col_sum > COL_MAX) ? COL_MAX[13:0] : col_sum[13:0];
                    if (mode_next == MODE_BAD)
                    begin
                        stop_next = 1'b1;
                        push      = 1'b1;
                        op.kind   = OP_STAT;
                        op.status = ST_ERR;
                    end
                    else if (mode_next == MODE_TRANS)
                    begin
                        push      = 1'b1;
                        op.kind   = OP_TRANS;
                        op.mode   = MODE_TRANS;
                        op.offset = lin_next;
                        op.count  = run_cnt;
                        lin_next  = lin_next + OFS_W'({run_cnt, 1'b0});
                    end
                    else
                    begin
                        left_next  = run_cnt;
                        bit_next   = 4'd0;
                        phase_next = PH_DATA;
                    end
                end
            end
        end
        if (!accept)
            push = 1'b0;
    end

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HEADER;
            mode_reg  <= MODE_YCC;
            ech_reg   <= 4'd0;
            left_reg  <= 12'd0;
            bit_reg   <= 4'd0;
            col_reg   <= 14'd0;
            row_reg   <= 13'd0;
            lin_reg   <= '0;
            stop_reg  <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            mode_reg  <= mode_next;
            ech_reg   <= ech_next;
            left_reg  <= left_next;
            bit_reg   <= bit_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            lin_reg   <= lin_next;
            stop_reg  <= stop_next;
        end
    end

    // Tile byte store
    always_ff @(posedge clk)
    begin
        if (accept && tb_we)
            tb_reg[c_bit] <= stream_byte;
    end

endmodule

@@ src/tyrd_queue.sv @@
// Two-entry queue of decoded operations between parser and pixel back end.
module tyrd_queue
    import tyrd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    input  logic pop,
    output logic full,
    output logic head_valid,
    output op_t  head_op
);

    op_t        mem_reg [2];
    logic       wr_reg;
    logic       rd_reg;
    logic [1:0] cnt_reg;

    assign full       = (cnt_reg == 2'd2);
    assign head_valid = (cnt_reg != 2'd0);
    assign head_op    = mem_reg[rd_reg];

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wr_reg <= ~wr_reg;
            if (pop)
                rd_reg <= ~rd_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= push_op;
    end

endmodule

@@ src/tyrd_back.sv @@
// Pixel back end: converts queued operations to result beats in an output register.
module tyrd_back
    import tyrd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  op_t              head_op,
    input  logic [31:0]      transparent_color,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [OFS_W-1:0] tile_offset,
    output logic [31:0]      pixel_top_left,
    output logic [31:0]      pixel_top_right,
    output logic [31:0]      pixel_bottom_left,
    output logic [31:0]      pixel_bottom_right,
    output logic [CNT_W-1:0] repeat_tiles,
    output logic [1:0]       status
);

    logic        valid_reg;
    logic [31:0] px [4];

    assign pop       = head_valid && (!valid_reg || !out_stall);
    assign out_valid = valid_reg;

    // Pixel words for the head operation
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            case (head_op.kind)
                OP_TILE:
                    if (head_op.mode == MODE_YCC)
                        px[i] = ycc_pixel(head_op.data[i], head_op.data[4], head_op.data[5]);
                    else
                        px[i] = rgb_pixel(head_op.data[3*i], head_op.data[3*i+1],
                                          head_op.data[3*i+2], transparent_color);
                OP_TRANS:
                    px[i] = transparent_color;
                default:
                    px[i] = 32'd0;
            endcase
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (!valid_reg || !out_stall)
            valid_reg <= head_valid;
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            tile_offset        <= head_op.offset;
            pixel_top_left     <= px[0];
            pixel_top_right    <= px[1];
            pixel_bottom_left  <= px[2];
            pixel_bottom_right <= px[3];
            repeat_tiles       <= head_op.count;
            status             <= head_op.status;
        end
    end

endmodule

@@ src/tiled_ycrcb_run_image_decoder_unit.sv @@
// Top level: configuration registers, byte parser, operation queue and pixel back end.
// A result passes from the parser into the queue entry, then from the queue head into the output register.
// Throughput: one byte per cycle; the parser takes one byte each cycle the queue has room.
// The back end converts one queued operation per cycle into the output register while it is empty or out_stall is low.
// Reset (rst_n low, asynchronous) clears parser, queue and output valid; registers
// return to width 640, height 480, transparent color 0.
module tiled_ycrcb_run_image_decoder_unit
    import tyrd_pkg::*;
#(
    parameter int MAX_WIDTH  = 4096,
    parameter int MAX_HEIGHT = 4096
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [31:0]      cfg_data,
    input  logic             in_valid,
    output logic             in_stall,
    input  logic [7:0]       stream_byte,
    input  logic             frame_start,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [OFS_W-1:0] tile_offset,
    output logic [31:0]      pixel_top_left,
    output logic [31:0]      pixel_top_right,
    output logic [31:0]      pixel_bottom_left,
    output logic [31:0]      pixel_bottom_right,
    output logic [CNT_W-1:0] repeat_tiles,
    output logic [1:0]       status
);

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_TCOLOR = 2'd2;

    logic [12:0] width_reg;
    logic [12:0] height_reg;
    logic [31:0] tcolor_reg;
    logic        accept;
    logic        push;
    op_t         push_op;
    logic        pop;
    logic        full;
    logic        head_valid;
    op_t         head_op;

    assign in_stall = full;
    assign accept   = in_valid && !full;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd640;
            height_reg <= 13'd480;
            tcolor_reg <= 32'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data[12:0];
                REG_HEIGHT: height_reg <= cfg_data[12:0];
                REG_TCOLOR: tcolor_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    tyrd_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .stream_byte  (stream_byte),
        .frame_start  (frame_start),
        .image_width  (width_reg),
        .image_height (height_reg),
        .push         (push),
        .op           (push_op)
    );

    tyrd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_op    (push_op),
        .pop        (pop),
        .full       (full),
        .head_valid (head_valid),
        .head_op    (head_op)
    );

    tyrd_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .head_valid         (head_valid),
        .head_op            (head_op),
        .transparent_color  (tcolor_reg),
        .pop                (pop),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .tile_offset        (tile_offset),
        .pixel_top_left     (pixel_top_left),
        .pixel_top_right    (pixel_top_right),
        .pixel_bottom_left  (pixel_bottom_left),
        .pixel_bottom_right (pixel_bottom_right),
        .repeat_tiles       (repeat_tiles),
        .status             (status)
    );

endmodule
